>>> hw/rtl/ppmc_pkg.sv
// Shared types and constants for the projectile pool block.
// No dependencies.
package ppmc_pkg;

    typedef enum logic [2:0] {
        OP_CLEAR = 3'd0,
        OP_FIRE  = 3'd1,
        OP_TICK  = 3'd2,
        OP_FIND  = 3'd3,
        OP_KILL  = 3'd4
    } t_op;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_BOTTOM = 2'd1;
    localparam logic [1:0] CFG_AGE    = 2'd2;
    localparam logic [1:0] CFG_RADIUS = 2'd3;

    // Off-screen margin in Q12.4 (20 px)
    localparam int MARGIN_Q = 320;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] speed_x;
        logic signed [15:0] speed_y;
        logic [9:0]         time_step;
        logic signed [15:0] box_x;
        logic signed [15:0] box_y;
        logic [14:0]        box_width;
        logic [14:0]        box_height;
        logic [4:0]         slot;
    } t_cmd;

endpackage

>>> hw/rtl/ppmc_front.sv
// Front end: accepts command transactions into a short queue.
// Depends on ppmc_pkg.
module ppmc_front #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  ppmc_pkg::t_cmd  i_cmd,
    output logic            o_valid,
    input  logic            i_ready,
    output ppmc_pkg::t_cmd  o_cmd
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    ppmc_pkg::t_cmd   r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             push, pop;

    assign o_ready = (r_cnt != (AW+1)'(DEPTH)) ? 1'b1 : 1'b0;
    assign o_valid = (r_cnt != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_cmd   = r_mem[r_rp];

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

>>> hw/rtl/ppmc_back.sv
// Back end: slot state and the per-slot sweep for every operation.
// Depends on ppmc_pkg.
module ppmc_back #(
    parameter int SLOTS = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  ppmc_pkg::t_cmd  i_cmd,
    input  logic [11:0]     i_scr_w,
    input  logic [11:0]     i_scr_b,
    input  logic [15:0]     i_max_age,
    input  logic [9:0]      i_radius,
    output logic            o_valid,
    input  logic            i_ready,
    output logic            o_fire_taken,
    output logic            o_hit_found,
    output logic [4:0]      o_hit_slot
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_WB   = 4'b0100,
        S_OUT  = 4'b1000
    } t_st;

    t_st                r_st;
    ppmc_pkg::t_cmd     r_cmd;
    logic [SW:0]        r_idx;
    logic [SLOTS-1:0]   r_act;
    logic signed [15:0] r_px [SLOTS];
    logic signed [15:0] r_py [SLOTS];
    logic signed [15:0] r_vx [SLOTS];
    logic signed [15:0] r_vy [SLOTS];
    logic [15:0]        r_age[SLOTS];
    logic               r_taken, r_found;
    logic [4:0]         r_hit;
    logic [19:0]        r_r2;
    // pipeline registers between multiply and writeback
    logic signed [26:0] r_mx, r_my;
    logic signed [15:0] r_cx, r_cy;
    logic [15:0]        r_ca;
    logic [SW-1:0]      r_ci;

    logic [SW-1:0]      idx;
    logic               act_i;
    assign idx   = r_idx[SW-1:0];
    assign act_i = r_act[idx];

    // find: nearest-point distance, per slot
    logic signed [17:0] bx0, bx1, by0, by1, px, py, nx, ny, dx, dy;
    logic [35:0]        d2;
    logic               hit_now;
    always_comb begin
        bx0 = 18'(r_cmd.box_x);
        by0 = 18'(r_cmd.box_y);
        bx1 = bx0 + 18'(signed'({1'b0, r_cmd.box_width}));
        by1 = by0 + 18'(signed'({1'b0, r_cmd.box_height}));
        px  = 18'(r_px[idx]);
        py  = 18'(r_py[idx]);
        nx  = (px < bx0) ? bx0 : ((px > bx1) ? bx1 : px);
        ny  = (py < by0) ? by0 : ((py > by1) ? by1 : py);
        dx  = px - nx;
        dy  = py - ny;
        d2  = 36'(dx * dx) + 36'(dy * dy);
        hit_now = act_i && (d2 <= 36'(r_r2));
    end

    // tick: floor shift of products, saturate, bounds
    logic signed [17:0] sx, sy, qx, qy;
    logic [16:0]        ag;
    logic [15:0]        na;
    logic               off;
    always_comb begin
        sx = 18'(r_cx) + 18'(r_mx >>> 10);
        sy = 18'(r_cy) + 18'(r_my >>> 10);
        qx = (sx > 18'sd32767) ? 18'sd32767 : ((sx < -18'sd32768) ? -18'sd32768 : sx);
        qy = (sy > 18'sd32767) ? 18'sd32767 : ((sy < -18'sd32768) ? -18'sd32768 : sy);
        ag = 17'(r_ca) + 17'(r_cmd.time_step);
        na = ag[16] ? 16'hFFFF : ag[15:0];
        // bounds compared signed: positions may sit left of or above the screen
        off = (qx < -18'sd320) ||
              (qx > signed'(18'(({6'd0, i_scr_w} + 18'd20) << 4))) ||
              (qy < -18'sd320) ||
              (qy > signed'(18'(({6'd0, i_scr_b} + 18'd20) << 4)));
    end

    logic last;
    assign last = (r_idx == (SW+1)'(SLOTS - 1));

    assign o_ready = (r_st == S_IDLE);
    assign o_valid = (r_st == S_OUT);
    assign o_fire_taken = r_taken;
    assign o_hit_found  = r_found;
    assign o_hit_slot   = r_hit;

    // Control sweep: one slot per cycle but for tick writebacks; tick has a one-stage multiply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_IDLE;
            r_act <= '0;
            r_idx <= '0;
        end else begin
            case (r_st)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd   <= i_cmd;
                        r_idx   <= '0;
                        r_taken <= 1'b0;
                        r_found <= 1'b0;
                        r_hit   <= '0;
                        r_r2    <= 20'(i_radius * i_radius);
                        r_st    <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_idx <= r_idx + 1'b1;
                    case (r_cmd.op)
                        ppmc_pkg::OP_CLEAR: begin
                            r_act[idx] <= 1'b0;
                            r_px[idx] <= '0; r_py[idx] <= '0;
                            r_vx[idx] <= '0; r_vy[idx] <= '0;
                            r_age[idx] <= '0;
                        end
                        ppmc_pkg::OP_FIRE: begin
                            if (!act_i && !r_taken) begin
                                r_act[idx] <= 1'b1;
                                r_px[idx] <= r_cmd.start_x;
                                r_py[idx] <= r_cmd.start_y;
                                r_vx[idx] <= r_cmd.speed_x;
                                r_vy[idx] <= r_cmd.speed_y;
                                r_age[idx] <= '0;
                                r_taken <= 1'b1;
                            end
                        end
                        ppmc_pkg::OP_FIND: begin
                            if (hit_now && !r_found) begin
                                r_found <= 1'b1;
                                r_hit   <= 5'(idx);
                            end
                        end
                        ppmc_pkg::OP_KILL: begin
                            if (32'(idx) == 32'(r_cmd.slot)) r_act[idx] <= 1'b0;
                        end
                        default: ;
                    endcase
                    if (r_cmd.op == ppmc_pkg::OP_TICK) begin
                        r_mx <= 27'(r_vx[idx] * signed'({1'b0, r_cmd.time_step}));
                        r_my <= 27'(r_vy[idx] * signed'({1'b0, r_cmd.time_step}));
                        r_cx <= r_px[idx];
                        r_cy <= r_py[idx];
                        r_ca <= r_age[idx];
                        r_ci <= act_i ? idx : r_ci;
                    end
                    if (last) r_st <= S_WB;
                    else if (r_cmd.op == ppmc_pkg::OP_TICK && act_i) r_st <= S_WB;
                end
                S_WB: begin
                    if (r_cmd.op == ppmc_pkg::OP_TICK && r_act[r_ci] &&
                        r_idx != '0 && r_ci == SW'(r_idx - 1'b1)) begin
                        r_px[r_ci]  <= 16'(qx);
                        r_py[r_ci]  <= 16'(qy);
                        r_age[r_ci] <= na;
                        if (off || na > i_max_age) r_act[r_ci] <= 1'b0;
                    end
                    r_st <= (r_idx == (SW+1)'(SLOTS)) ? S_OUT : S_RUN;
                end
                S_OUT: begin
                    if (i_ready) r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

>>> hw/rtl/projectile_pool_motion_collide.sv
// Projectile pool: clear, fire, tick, find and kill over POOL_SLOTS slots.
// Each command is accepted, swept over the slots, written back and held as a result until
// taken; a tick also enters writeback after each active slot below the last. The sweep visits
// one slot per cycle, pausing for tick writebacks; the two-entry queue takes commands meanwhile.
// Reset (synchronous, active low) empties the pool and loads default registers.
module projectile_pool_motion_collide #(
    parameter int POOL_SLOTS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_operation,
    input  logic signed [15:0] i_start_x,
    input  logic signed [15:0] i_start_y,
    input  logic signed [15:0] i_speed_x,
    input  logic signed [15:0] i_speed_y,
    input  logic [9:0]         i_time_step,
    input  logic signed [15:0] i_box_x,
    input  logic signed [15:0] i_box_y,
    input  logic [14:0]        i_box_width,
    input  logic [14:0]        i_box_height,
    input  logic [4:0]         i_slot,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_fire_taken,
    output logic               o_hit_found,
    output logic [4:0]         o_hit_slot
);
    ppmc_pkg::t_cmd cmd_in, cmd_q;
    logic           q_valid, q_ready;
    logic [11:0]    r_scr_w, r_scr_b;
    logic [15:0]    r_max_age;
    logic [9:0]     r_radius;

    assign cmd_in = '{op: i_operation, start_x: i_start_x, start_y: i_start_y,
                      speed_x: i_speed_x, speed_y: i_speed_y, time_step: i_time_step,
                      box_x: i_box_x, box_y: i_box_y, box_width: i_box_width,
                      box_height: i_box_height, slot: i_slot};

    // Configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w   <= 12'd800;
            r_scr_b   <= 12'd600;
            r_max_age <= 16'd2048;
            r_radius  <= 10'd64;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ppmc_pkg::CFG_WIDTH:  r_scr_w   <= i_cfg_data[11:0];
                ppmc_pkg::CFG_BOTTOM: r_scr_b   <= i_cfg_data[11:0];
                ppmc_pkg::CFG_AGE:    r_max_age <= i_cfg_data;
                ppmc_pkg::CFG_RADIUS: r_radius  <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    ppmc_front #(.DEPTH(2)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_cmd(cmd_in),
        .o_valid(q_valid), .i_ready(q_ready), .o_cmd(cmd_q)
    );

    ppmc_back #(.SLOTS(POOL_SLOTS)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .o_ready(q_ready), .i_cmd(cmd_q),
        .i_scr_w(r_scr_w), .i_scr_b(r_scr_b), .i_max_age(r_max_age),
        .i_radius(r_radius), .o_valid, .i_ready, .o_fire_taken, .o_hit_found,
        .o_hit_slot
    );
endmodule

>>> hw/rtl/ppmc_checker.sv
// Port-level checks for the projectile pool.
// Bound to projectile_pool_motion_collide.
module ppmc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_fire_taken,
    input logic       o_hit_found,
    input logic [4:0] o_hit_slot
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_hit_slot))
        else $error("result dropped while stalled");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_fire_taken && o_hit_found))
        else $error("fire and hit both set");
    a_nohit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit_found |-> o_hit_slot == 5'd0)
        else $error("slot without hit");
endmodule

bind projectile_pool_motion_collide ppmc_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_ready, .o_fire_taken, .o_hit_found, .o_hit_slot
);
